// ===== rtl/psm_pkg.sv =====
`timescale 1ns / 1ps
// psm_pkg: shared types for the pair sum stream matcher
// no dependencies

package psm_pkg;

	// lookup token handed from cell to cell
	typedef struct packed {
		logic live;
		logic comp_hit;
		logic value_hit;
		logic key_hit;
	} psm_tok_t;

endpackage

// ===== rtl/psm_in_if.sv =====
`timescale 1ns / 1ps
// psm_in_if: input item channel, valid/ready with value and first_of_set
// no dependencies

interface psm_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          first_of_set;

	modport source (output valid, output value, output first_of_set, input ready);
	modport sink (input valid, input value, input first_of_set, output ready);
endinterface

// ===== rtl/psm_out_if.sv =====
`timescale 1ns / 1ps
// psm_out_if: result item channel, valid/ready with match fields
// no dependencies

interface psm_out_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          match_found;
	logic                          new_pair;
	logic signed [VALUE_WIDTH-1:0] partner;
	logic signed [VALUE_WIDTH-1:0] this_value;
	logic                          store_full_drop;

	modport source (
		output valid, output match_found, output new_pair, output partner,
		output this_value, output store_full_drop, input ready
	);
	modport sink (
		input valid, input match_found, input new_pair, input partner,
		input this_value, input store_full_drop, output ready
	);
endinterface

// ===== rtl/psm_cfg_if.sv =====
`timescale 1ns / 1ps
// psm_cfg_if: configuration write channel for target_sum
// no dependencies

interface psm_cfg_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pair_sum_stream_matcher.sv =====
`timescale 1ns / 1ps
// pair_sum_stream_matcher: streaming two-sum matcher built as a chain of cells
// depends on psm_pkg, psm_cell, psm_in_if, psm_out_if, psm_cfg_if
//
// channel  | dir | handshake    | payload
// items    | in  | valid/ready  | value, first_of_set
// results  | out | valid/ready  | match_found, new_pair, partner, this_value, store_full_drop
// cfg      | in  | valid/ready  | data (target_sum)
//
// a lookup token walks the STORE_DEPTH cells one per cycle; results.valid rises from the
// output register once the token leaves the last cell, and a new item is not taken
// until the token has left the chain and no stalled result is held
// inserts go to the cell at the fill count when the token leaves the chain
// reset clears valid bits, counts and target_sum; cfg is always ready
// a stalled result waits in a one-entry hold while the next item is not taken

module pair_sum_stream_matcher import psm_pkg::*; #(
	parameter int STORE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	psm_in_if.sink     items,
	psm_out_if.source  results,
	psm_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	logic signed [VALUE_WIDTH-1:0] target_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic signed [VALUE_WIDTH:0]   comp_wide;
	logic signed [VALUE_WIDTH-1:0] comp_q;
	logic                          comp_ok_q;
	logic signed [VALUE_WIDTH-1:0] key;
	logic                          busy_q;
	logic                          start_q;
	logic                          pend_q;
	logic [CNT_W-1:0]              n_seen_q;
	logic [CNT_W-1:0]              n_rep_q;
	logic                          in_xfer;
	logic                          clear;
	logic                          done;
	logic                          fin_match;
	logic                          fin_new;
	logic                          fin_drop;
	logic                          ins_seen;
	logic                          ins_rep;
	logic                          out_free;
	logic [STORE_DEPTH-1:0]        seen_we;
	logic [STORE_DEPTH-1:0]        rep_we;
	psm_tok_t                      chain [STORE_DEPTH+1];

	logic                          out_valid_q;
	logic                          out_match_q;
	logic                          out_new_q;
	logic signed [VALUE_WIDTH-1:0] out_partner_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic                          out_drop_q;
	logic                          p_match_q;
	logic                          p_new_q;
	logic signed [VALUE_WIDTH-1:0] p_partner_q;
	logic signed [VALUE_WIDTH-1:0] p_value_q;
	logic                          p_drop_q;

	assign items.ready = !busy_q && !pend_q;
	assign in_xfer     = items.valid && items.ready;
	assign clear       = in_xfer && items.first_of_set;
	assign cfg.ready   = 1'b1;

	assign comp_wide = {target_q[VALUE_WIDTH-1], target_q}
		- {items.value[VALUE_WIDTH-1], items.value};

	// smaller pair member keys the reported store
	assign key = (comp_q < value_q) ? comp_q : value_q;

	assign chain[0] = '{live: start_q, comp_hit: 1'b0, value_hit: 1'b0, key_hit: 1'b0};

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		assign seen_we[i] = ins_seen && (n_seen_q == CNT_W'(i));
		assign rep_we[i]  = ins_rep && (n_rep_q == CNT_W'(i));

		psm_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (clear),
			.seen_we (seen_we[i]),
			.rep_we  (rep_we[i]),
			.value   (value_q),
			.comp    (comp_q),
			.comp_ok (comp_ok_q),
			.key     (key),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign done      = chain[STORE_DEPTH].live;
	assign fin_match = chain[STORE_DEPTH].comp_hit;
	assign fin_new   = fin_match && !chain[STORE_DEPTH].key_hit;
	assign fin_drop  = !fin_match && !chain[STORE_DEPTH].value_hit
		&& (n_seen_q == CNT_W'(STORE_DEPTH));
	assign ins_seen  = done && !fin_match && !chain[STORE_DEPTH].value_hit
		&& (n_seen_q != CNT_W'(STORE_DEPTH));
	assign ins_rep   = done && fin_new && (n_rep_q != CNT_W'(STORE_DEPTH));
	assign out_free  = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			pend_q      <= 1'b0;
			n_seen_q    <= '0;
			n_rep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) target_q <= cfg.data;
			start_q <= in_xfer;
			if (in_xfer) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;

			if (clear) begin
				n_seen_q <= '0;
				n_rep_q  <= '0;
			end else begin
				if (ins_seen) n_seen_q <= n_seen_q + 1'b1;
				if (ins_rep) n_rep_q <= n_rep_q + 1'b1;
			end

			priority if (pend_q && out_free) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (done) begin
				pend_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q   <= items.value;
			comp_q    <= comp_wide[VALUE_WIDTH-1:0];
			comp_ok_q <= (comp_wide[VALUE_WIDTH] == comp_wide[VALUE_WIDTH-1]);
		end
		if (pend_q && out_free) begin
			out_match_q   <= p_match_q;
			out_new_q     <= p_new_q;
			out_partner_q <= p_partner_q;
			out_value_q   <= p_value_q;
			out_drop_q    <= p_drop_q;
		end else if (done && out_free) begin
			out_match_q   <= fin_match;
			out_new_q     <= fin_new;
			out_partner_q <= fin_match ? comp_q : '0;
			out_value_q   <= value_q;
			out_drop_q    <= fin_drop;
		end
		if (done && !out_free) begin
			p_match_q   <= fin_match;
			p_new_q     <= fin_new;
			p_partner_q <= fin_match ? comp_q : '0;
			p_value_q   <= value_q;
			p_drop_q    <= fin_drop;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.match_found     = out_match_q;
	assign results.new_pair        = out_new_q;
	assign results.partner         = out_partner_q;
	assign results.this_value      = out_value_q;
	assign results.store_full_drop = out_drop_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_q && start_q)
		else $error("token not launched after transfer");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q && !start_q)
		else $error("token left chain while idle");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(seen_we) && $onehot0(rep_we))
		else $error("more than one cell written");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("held result without a result in the output register");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		n_rep_q <= CNT_W'(STORE_DEPTH) && n_seen_q <= CNT_W'(STORE_DEPTH))
		else $error("fill count past store depth");
`endif

endmodule

// ===== rtl/psm_cell.sv =====
`timescale 1ns / 1ps
// psm_cell: one entry of the seen store and one of the reported store,
// compares against the broadcast query and passes the token on; uses psm_pkg

module psm_cell import psm_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          seen_we,
	input  logic                          rep_we,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic signed [VALUE_WIDTH-1:0] comp,
	input  logic                          comp_ok,
	input  logic signed [VALUE_WIDTH-1:0] key,
	input  psm_tok_t                      tok_in,
	output psm_tok_t                      tok_out
);

	logic                          seen_valid_q;
	logic                          rep_valid_q;
	logic signed [VALUE_WIDTH-1:0] seen_val_q;
	logic signed [VALUE_WIDTH-1:0] rep_key_q;
	psm_tok_t                      tok_q;
	psm_tok_t                      tok_d;

	always_comb begin
		tok_d           = tok_in;
		tok_d.comp_hit  = tok_in.comp_hit | (seen_valid_q & comp_ok & (seen_val_q == comp));
		tok_d.value_hit = tok_in.value_hit | (seen_valid_q & (seen_val_q == value));
		tok_d.key_hit   = tok_in.key_hit | (rep_valid_q & (rep_key_q == key));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_valid_q <= 1'b0;
			rep_valid_q  <= 1'b0;
			tok_q        <= '0;
		end else begin
			tok_q <= tok_d;
			if (clear) begin
				seen_valid_q <= 1'b0;
				rep_valid_q  <= 1'b0;
			end else begin
				if (seen_we) seen_valid_q <= 1'b1;
				if (rep_we) rep_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seen_we) seen_val_q <= value;
		if (rep_we) rep_key_q <= key;
	end

	assign tok_out = tok_q;

endmodule
